FILE: hdl/morse_digit_timing_encoder_defines.svh
// Assertion macros shared by the Morse digit timing encoder RTL.
`ifndef MORSE_DIGIT_TIMING_ENCODER_DEFINES_SVH
`define MORSE_DIGIT_TIMING_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

`define MDTE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

`define MDTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define MDTE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define MDTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/mdte_pkg.sv
// Shared constants, request codes and the digit symbol table of the encoder.
`timescale 1ns / 1ps
`default_nettype none

package mdte_pkg;

  localparam int STACK_DEPTH_DEF = 30;
  localparam int ID_W            = 8;
  localparam int BCD_W           = 12;
  localparam int SYMS_PER_DIGIT  = 10;
  localparam int SYM_W           = $clog2(SYMS_PER_DIGIT);

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] DUR_EMPTY = 2'd0;
  localparam logic [1:0] DUR_SHORT = 2'd1;
  localparam logic [1:0] DUR_LONG  = 2'd3;

  // Bit k of each pattern is the k-th symbol pushed for that digit.
  function automatic logic [SYMS_PER_DIGIT-1:0] digit_pattern(input logic [3:0] digit);
    logic [SYMS_PER_DIGIT-1:0] pat;
    case (digit)
      4'd0: pat = 10'h2AB;
      4'd1: pat = 10'h0AB;
      4'd2: pat = 10'h02B;
      4'd3: pat = 10'h00B;
      4'd4: pat = 10'h003;
      4'd5: pat = 10'h001;
      4'd6: pat = 10'h201;
      4'd7: pat = 10'h281;
      4'd8: pat = 10'h2A1;
      4'd9: pat = 10'h2A9;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mdte_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mdte_ram #(
  parameter int WIDTH  = 1,
  parameter int DEPTH  = 30,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/mdte_bcd.sv
// Bit-serial binary to decimal converter using shift and add-three steps.
`timescale 1ns / 1ps
`default_nettype none

module mdte_bcd import mdte_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [ID_W-1:0]  bin,
  output logic                  done,
  output logic      [BCD_W-1:0] bcd
);

  localparam int CNT_W = $clog2(ID_W);

  logic [ID_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int n = 0; n < BCD_W / 4; n++) begin
      adj[4*n +: 4] = (bcd_r[4*n +: 4] >= 4'd5) ? bcd_r[4*n +: 4] + 4'd3 : bcd_r[4*n +: 4];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt = bin;
      bcd_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = {adj[BCD_W-2:0], bin_r[ID_W-1]};
      bin_nxt = {bin_r[ID_W-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(ID_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

`default_nettype wire

FILE: hdl/morse_digit_timing_encoder.sv
// Top level of the Morse digit timing encoder with its request sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "morse_digit_timing_encoder_defines.svh"

// A request is taken when start is high and busy is low; in_req_type selects
// load, pop or clear, and in_id_value is used only by a load.
// Every request gives exactly one result, shown for one cycle with out_valid.
// A load converts the identifier to decimal in a bit-serial converter, then
// writes one symbol per cycle into the stack RAM; a refused load or an
// identifier of zero answers on the next cycle. A pop reads the RAM through
// its registered port, and the ST_POP state registers the result from the
// read data. Clear and the unused code answer on the next cycle. busy stays
// high while a load or a pop is in progress. The receiver cannot stall, so
// results are never held back.
// Reset empties the stack and idles the sequencer; stack contents are left
// undefined, since only entries below the fill level are ever read.

module morse_digit_timing_encoder import mdte_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [1:0]      in_req_type,
  input  wire logic [ID_W-1:0] in_id_value,
  output logic                 out_valid,
  output logic      [1:0]      out_duration_units,
  output logic                 out_load_refused
);

  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PUSH, ST_POP} state_t;

  state_t                    state_r, state_nxt;
  logic [FILL_W-1:0]         fill_r, fill_nxt;
  logic [1:0]                ndig_r, ndig_nxt;
  logic [1:0]                dig_idx_r, dig_idx_nxt;
  logic [SYM_W-1:0]          sym_cnt_r, sym_cnt_nxt;
  logic [SYMS_PER_DIGIT-1:0] pat_r, pat_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_dur_r, out_dur_nxt;
  logic                      out_ref_r, out_ref_nxt;

  logic              accept;
  logic [1:0]        ndig;
  logic [5:0]        need;
  logic [FILL_W:0]   fit_sum;
  logic              fits;
  logic              bcd_start;
  logic              bcd_done;
  logic [BCD_W-1:0]  bcd;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic              ram_rdata;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (in_id_value >= ID_W'(100)) begin
      ndig = 2'd3;
    end else if (in_id_value >= ID_W'(10)) begin
      ndig = 2'd2;
    end else begin
      ndig = 2'd1;
    end
    need    = 6'(ndig) * 6'(SYMS_PER_DIGIT);
    fit_sum = {1'b0, fill_r} + (FILL_W + 1)'(need);
    fits    = (fit_sum <= (FILL_W + 1)'(STACK_DEPTH));
  end

  assign ram_raddr = (fill_r == '0) ? '0 : ADDR_W'(fill_r - FILL_W'(1));

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ndig_nxt      = ndig_r;
    dig_idx_nxt   = dig_idx_r;
    sym_cnt_nxt   = sym_cnt_r;
    pat_nxt       = pat_r;
    out_valid_nxt = 1'b0;
    out_dur_nxt   = out_dur_r;
    out_ref_nxt   = out_ref_r;
    bcd_start     = 1'b0;
    ram_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_dur_nxt = DUR_EMPTY;
          out_ref_nxt = 1'b0;
          case (in_req_type)
            REQ_LOAD: begin
              if (in_id_value == '0) begin
                out_valid_nxt = 1'b1;
              end else if (!fits) begin
                out_valid_nxt = 1'b1;
                out_ref_nxt   = 1'b1;
              end else begin
                bcd_start = 1'b1;
                ndig_nxt  = ndig;
                state_nxt = ST_CONV;
              end
            end
            REQ_POP: begin
              if (fill_r != '0) begin
                fill_nxt  = fill_r - FILL_W'(1);
                state_nxt = ST_POP;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            REQ_CLEAR: begin
              fill_nxt      = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          pat_nxt     = digit_pattern(bcd[3:0]);
          dig_idx_nxt = '0;
          sym_cnt_nxt = '0;
          state_nxt   = ST_PUSH;
        end
      end
      ST_PUSH: begin
        ram_we      = 1'b1;
        fill_nxt    = fill_r + FILL_W'(1);
        pat_nxt     = {1'b0, pat_r[SYMS_PER_DIGIT-1:1]};
        sym_cnt_nxt = sym_cnt_r + SYM_W'(1);
        if (sym_cnt_r == SYM_W'(SYMS_PER_DIGIT - 1)) begin
          if (dig_idx_r == ndig_r - 2'd1) begin
            out_valid_nxt = 1'b1;
            out_dur_nxt   = DUR_EMPTY;
            out_ref_nxt   = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            dig_idx_nxt = dig_idx_r + 2'd1;
            sym_cnt_nxt = '0;
            pat_nxt     = (dig_idx_r == 2'd0) ? digit_pattern(bcd[7:4])
                                              : digit_pattern(bcd[11:8]);
          end
        end
      end
      ST_POP: begin
        out_valid_nxt = 1'b1;
        out_dur_nxt   = ram_rdata ? DUR_LONG : DUR_SHORT;
        out_ref_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ndig_r    <= ndig_nxt;
    dig_idx_r <= dig_idx_nxt;
    sym_cnt_r <= sym_cnt_nxt;
    pat_r     <= pat_nxt;
    out_dur_r <= out_dur_nxt;
    out_ref_r <= out_ref_nxt;
  end

  mdte_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bcd_start),
    .bin   (in_id_value),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  mdte_ram #(
    .WIDTH  (1),
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[ADDR_W-1:0]),
    .wdata (pat_r[0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_duration_units = out_dur_r;
  assign out_load_refused   = out_ref_r;

  `MDTE_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_W'(STACK_DEPTH))
  `MDTE_ASSERT_IMPLY(a_push_room, clk, rst_n, ram_we, fill_r < FILL_W'(STACK_DEPTH))
  `MDTE_ASSERT_IMPLY(a_refuse_clean, clk, rst_n, out_load_refused && out_valid, out_duration_units == DUR_EMPTY)
  `MDTE_ASSERT_NEXT(a_pop_dec, clk, rst_n, accept && in_req_type == REQ_POP && fill_r != '0, fill_r + FILL_W'(1) == $past(fill_r))

endmodule

`default_nettype wire

FILE: dv/morse_digit_timing_encoder_checker.sv
// Checker that predicts every encoder request and compares each result strobe.
`timescale 1ns / 1ps

module morse_digit_timing_encoder_checker import mdte_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  logic [1:0]      in_req_type,
  input  logic [ID_W-1:0] in_id_value,
  input  logic            out_valid,
  input  logic [1:0]      out_duration_units,
  input  logic            out_load_refused,
  output int              mismatch_count,
  output int              awaited_count
);

  typedef struct packed {
    logic [1:0] duration_units;
    logic       load_refused;
  } morse_result_t;

  // Symbol k of a digit is bit k of its entry; a set bit is a long element.
  localparam logic [9:0][SYMS_PER_DIGIT-1:0] DIGIT_SYMBOLS = {
    10'h2A9, 10'h2A1, 10'h281, 10'h201, 10'h001,
    10'h003, 10'h00B, 10'h02B, 10'h0AB, 10'h2AB
  };

  bit            symbol_stack [STACK_DEPTH_DEF];
  int unsigned   stack_fill;
  morse_result_t awaited_results [$];

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
    stack_fill     = 0;
  end

  task automatic predict_request(input logic [1:0] req, input logic [ID_W-1:0] id,
                                 output morse_result_t res);
    int unsigned digits;
    int unsigned rest;
    logic [SYMS_PER_DIGIT-1:0] pat;
    res = '0;
    case (req)
      REQ_LOAD: begin
        if (id != '0) begin
          digits = (id >= 100) ? 3 : ((id >= 10) ? 2 : 1);
          if (stack_fill + SYMS_PER_DIGIT * digits > STACK_DEPTH_DEF) begin
            res.load_refused = 1'b1;
          end else begin
            rest = id;
            repeat (digits) begin
              pat = DIGIT_SYMBOLS[rest % 10];
              for (int k = 0; k < SYMS_PER_DIGIT; k++) begin
                symbol_stack[stack_fill] = pat[k];
                stack_fill++;
              end
              rest = rest / 10;
            end
          end
        end
      end
      REQ_POP: begin
        if (stack_fill > 0) begin
          stack_fill--;
          res.duration_units = symbol_stack[stack_fill] ? DUR_LONG : DUR_SHORT;
        end else begin
          res.duration_units = DUR_EMPTY;
        end
      end
      REQ_CLEAR: begin
        stack_fill = 0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    morse_result_t want;
    morse_result_t got;
    if (!rst_n) begin
      stack_fill = 0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        got.duration_units = out_duration_units;
        got.load_refused   = out_load_refused;
        if (awaited_results.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("Unexpected result: duration %0d refused %0d",
                     got.duration_units, got.load_refused);
          end
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("Result mismatch: expected duration %0d refused %0d, got duration %0d refused %0d",
                       want.duration_units, want.load_refused,
                       got.duration_units, got.load_refused);
            end
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        predict_request(in_req_type, in_id_value, want);
        awaited_results.push_back(want);
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

FILE: dv/morse_digit_timing_encoder_test.sv
// Testbench top that drives encoder requests and reports the final verdict.
`timescale 1ns / 1ps

module morse_digit_timing_encoder_test;
  import mdte_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         ITEM_TARGET = 1570;
  localparam int         PHASE_ITEMS = 150;
  localparam int         CYCLE_LIMIT = 1000000;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  logic [1:0]      in_req_type;
  logic [ID_W-1:0] in_id_value;
  logic            out_valid;
  logic [1:0]      out_duration_units;
  logic            out_load_refused;

  int mismatch_count;
  int awaited_count;
  int requests_sent;
  int sender_idle_pct;
  int cycle_count;

  morse_digit_timing_encoder i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_id_value        (in_id_value),
    .out_valid          (out_valid),
    .out_duration_units (out_duration_units),
    .out_load_refused   (out_load_refused)
  );

  morse_digit_timing_encoder_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_id_value        (in_id_value),
    .out_valid          (out_valid),
    .out_duration_units (out_duration_units),
    .out_load_refused   (out_load_refused),
    .mismatch_count     (mismatch_count),
    .awaited_count      (awaited_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request
  // is taken, with start still high.
  task automatic issue_request(input logic [1:0] req, input logic [ID_W-1:0] id);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start       <= 1'b0;
      in_req_type <= 2'($urandom);
      in_id_value <= ID_W'($urandom);
      @(negedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_id_value <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return ID_W'($urandom_range(1, 9));
    if (r < 70) return ID_W'($urandom_range(10, 99));
    if (r < 90) return ID_W'($urandom_range(100, 255));
    return ID_W'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    int phase;
    int next_phase_at;
    int loads;
    int pops;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req_type     = REQ_LOAD;
    in_id_value     = '0;
    requests_sent   = 0;
    sender_idle_pct = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty pops, zero id, digit counts, refusals, clear.
    issue_request(REQ_POP, 8'd0);
    issue_request(REQ_LOAD, 8'd0);
    issue_request(REQ_LOAD, 8'd9);
    issue_request(REQ_LOAD, 8'd10);
    issue_request(REQ_LOAD, 8'd99);
    issue_request(REQ_LOAD, 8'd1);
    issue_request(REQ_LOAD, 8'd0);
    issue_request(REQ_POP, 8'd255);
    issue_request(REQ_POP, 8'd0);
    issue_request(REQ_POP, 8'd0);
    issue_request(REQ_CLEAR, 8'd255);
    issue_request(REQ_POP, 8'd0);
    issue_request(REQ_LOAD, 8'd255);
    issue_request(REQ_LOAD, 8'd5);
    issue_request(REQ_POP, 8'd0);
    issue_request(REQ_LOAD, 8'd5);
    issue_request(REQ_UNUSED, 8'd255);
    issue_request(REQ_CLEAR, 8'd0);
    issue_request(REQ_LOAD, 8'd100);
    issue_request(REQ_LOAD, 8'd128);
    issue_request(REQ_UNUSED, 8'd0);
    issue_request(REQ_POP, 8'd170);
    issue_request(REQ_POP, 8'd85);
    issue_request(REQ_CLEAR, 8'd0);
    drain_results();

    // Random part: mostly clear/load/pop runs, some stray requests.
    phase         = 0;
    next_phase_at = requests_sent + PHASE_ITEMS;
    while (requests_sent < ITEM_TARGET) begin
      if (requests_sent >= next_phase_at) begin
        phase++;
        next_phase_at = requests_sent + PHASE_ITEMS;
        case (phase % 3)
          0: sender_idle_pct = 0;
          1: sender_idle_pct = 67;
          default: sender_idle_pct = 12;
        endcase
        if ($urandom_range(0, 1) == 0) drain_results();
      end
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 1) == 0) issue_request(REQ_CLEAR, ID_W'($urandom));
        loads = $urandom_range(1, 3);
        repeat (loads) issue_request(REQ_LOAD, pick_id());
        pops = $urandom_range(3, 34);
        repeat (pops) issue_request(REQ_POP, ID_W'($urandom));
      end else begin
        issue_request(2'($urandom_range(0, 3)), ID_W'($urandom));
      end
    end

    drain_results();
    repeat (60) @(negedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
